@@ rtl/core/fbpfc_pkg.sv @@
// ----------------------------------------------------------------------------
// fbpfc_pkg
// Types, register map and helpers for the framebuffer pixel format converter.
// ----------------------------------------------------------------------------
package fbpfc_pkg;

  localparam int MAX_COLUMNS = 1024;
  localparam int MAX_ROWS    = 1024;
  localparam int COL_W       = $clog2(MAX_COLUMNS);
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int RES_W       = 11;
  localparam int ADDR_W      = 22;
  localparam int PITCH_W     = 13;
  localparam int OFFS_W      = COL_W + 2;
  localparam int PADDR_W     = 5;

  localparam logic [RES_W-1:0] MAX_COL_RES = RES_W'(MAX_COLUMNS);
  localparam logic [RES_W-1:0] MAX_ROW_RES = RES_W'(MAX_ROWS);

  localparam logic [1:0] FMT_PACKED = 2'd0;
  localparam logic [1:0] FMT_RGB24  = 2'd1;
  localparam logic [1:0] FMT_RGB32  = 2'd2;

  localparam logic [3:0] BE_PACKED = 4'h3;
  localparam logic [3:0] BE_WIDE   = 4'h7;

  localparam logic [PADDR_W-1:0] REG_PIXEL_FORMAT   = 5'h00;
  localparam logic [PADDR_W-1:0] REG_MASK_SIZES     = 5'h04;
  localparam logic [PADDR_W-1:0] REG_MASK_POSITIONS = 5'h08;
  localparam logic [PADDR_W-1:0] REG_X_RESOLUTION   = 5'h0C;
  localparam logic [PADDR_W-1:0] REG_Y_RESOLUTION   = 5'h10;
  localparam logic [PADDR_W-1:0] REG_LINE_PITCH     = 5'h14;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] byte_address;
    logic [31:0]       pixel_bytes;
    logic [3:0]        byte_enable;
    logic              end_of_line;
    logic              end_of_frame;
  } pixel_out_t;

  function automatic logic [15:0] pack_channel(input logic [7:0] v,
                                               input logic [3:0] size,
                                               input logic [4:0] pos);
    logic [3:0]  sz;
    logic [31:0] shifted;
    sz      = (size > 4'd8) ? 4'd8 : size;
    shifted = {24'h0, v >> (4'd8 - sz)} << pos;
    if (size == 4'd0) begin
      shifted = '0;
    end
    return shifted[15:0];
  endfunction

  function automatic logic [RES_W-1:0] limit_res(input logic [RES_W-1:0] r,
                                                 input logic [RES_W-1:0] maxv);
    logic [RES_W-1:0] res;
    if (r == '0) begin
      res = RES_W'(1);
    end else if (r > maxv) begin
      res = maxv;
    end else begin
      res = r;
    end
    return res;
  endfunction

endpackage

@@ rtl/core/framebuffer_pixel_format_converter.sv @@
// ----------------------------------------------------------------------------
// framebuffer_pixel_format_converter
// Converts RGB888 source pixels in raster order into framebuffer writes.
// ----------------------------------------------------------------------------
// Usage:
//   src channel: one RGB888 pixel per item, raster order, valid/stall.
//   dst channel: byte address, pixel bytes, byte enable and end of line /
//   end of frame flags per item, valid/stall.
//   APB port sets format, channel masks, resolution and line pitch; write
//   it only while no item is in flight.
// Timing:
//   An item accepted from src is held in the input register and then in the
//   result register, from which it is presented on dst.
//   One item per cycle is sustained while dst does not stall; the input and
//   result registers form a two-stage pipeline, so the block still takes an
//   item into an empty input register while a result waits on a stalled dst.
// Reset:
//   Column, row and line base clear to zero, registers take their defaults
//   and both stages empty.
// Stall:
//   A stalled dst holds its result; once both stages are full, src stalls.
// ----------------------------------------------------------------------------
module framebuffer_pixel_format_converter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            src_valid,
  output logic                            src_stall,
  input  fbpfc_pkg::pixel_in_t            src_data,
  output logic                            dst_valid,
  input  logic                            dst_stall,
  output fbpfc_pkg::pixel_out_t           dst_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fbpfc_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import fbpfc_pkg::*;

  logic [1:0]         pixel_format;
  logic [11:0]        mask_sizes;
  logic [14:0]        mask_positions;
  logic [RES_W-1:0]   x_resolution;
  logic [RES_W-1:0]   y_resolution;
  logic [PITCH_W-1:0] line_pitch;

  logic [COL_W-1:0]  column;
  logic [ROW_W-1:0]  row;
  logic [ADDR_W-1:0] row_base;

  logic              s1_valid;
  pixel_in_t         s1_pix;
  logic [ADDR_W-1:0] s1_addr;
  logic              s1_eol;
  logic              s1_eof;

  logic              cfg_write;
  logic              src_accept;
  logic              out_en;
  logic              s1_move;
  logic [RES_W-1:0]  xres;
  logic [RES_W-1:0]  yres;
  logic              eol;
  logic              eof;
  logic [OFFS_W-1:0] col_offset;
  logic [ADDR_W-1:0] addr;
  logic [15:0]       packed_sum;
  pixel_out_t        result;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format   <= FMT_RGB32;
      mask_sizes     <= 12'd1381;
      mask_positions <= 15'd171;
      x_resolution   <= 11'd320;
      y_resolution   <= 11'd200;
      line_pitch     <= 13'd1280;
    end else if (cfg_write) begin
      unique case (paddr)
        REG_PIXEL_FORMAT:   pixel_format   <= pwdata[1:0];
        REG_MASK_SIZES:     mask_sizes     <= pwdata[11:0];
        REG_MASK_POSITIONS: mask_positions <= pwdata[14:0];
        REG_X_RESOLUTION:   x_resolution   <= pwdata[RES_W-1:0];
        REG_Y_RESOLUTION:   y_resolution   <= pwdata[RES_W-1:0];
        REG_LINE_PITCH:     line_pitch     <= pwdata[PITCH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      REG_PIXEL_FORMAT:   prdata = {30'h0, pixel_format};
      REG_MASK_SIZES:     prdata = {20'h0, mask_sizes};
      REG_MASK_POSITIONS: prdata = {17'h0, mask_positions};
      REG_X_RESOLUTION:   prdata = {{(32-RES_W){1'b0}}, x_resolution};
      REG_Y_RESOLUTION:   prdata = {{(32-RES_W){1'b0}}, y_resolution};
      REG_LINE_PITCH:     prdata = {{(32-PITCH_W){1'b0}}, line_pitch};
      default:            prdata = '0;
    endcase
  end

  // pipeline control
  assign out_en     = !dst_valid || !dst_stall;
  assign s1_move    = s1_valid && out_en;
  assign src_stall  = s1_valid && !out_en;
  assign src_accept = src_valid && !src_stall;

  // position and address
  assign xres = limit_res(x_resolution, MAX_COL_RES);
  assign yres = limit_res(y_resolution, MAX_ROW_RES);
  assign eol  = ({1'b0, column} + RES_W'(1)) >= xres;
  assign eof  = eol && (({1'b0, row} + RES_W'(1)) >= yres);

  always_comb begin
    unique case (pixel_format)
      FMT_PACKED: col_offset = {1'b0, column, 1'b0};
      FMT_RGB24:  col_offset = {1'b0, column, 1'b0} + {2'b00, column};
      default:    col_offset = {column, 2'b00};
    endcase
  end

  assign addr = row_base + {{(ADDR_W-OFFS_W){1'b0}}, col_offset};

  always_ff @(posedge clk) begin
    if (rst) begin
      column   <= '0;
      row      <= '0;
      row_base <= '0;
    end else if (src_accept) begin
      if (eol) begin
        column <= '0;
        if (eof) begin
          row      <= '0;
          row_base <= '0;
        end else begin
          row      <= row + ROW_W'(1);
          row_base <= row_base + {{(ADDR_W-PITCH_W){1'b0}}, line_pitch};
        end
      end else begin
        column <= column + COL_W'(1);
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= src_accept || (s1_valid && !out_en);
    end
  end

  always_ff @(posedge clk) begin
    if (src_accept) begin
      s1_pix  <= src_data;
      s1_addr <= addr;
      s1_eol  <= eol;
      s1_eof  <= eof;
    end
  end

  // conversion
  assign packed_sum = pack_channel(s1_pix.red,   mask_sizes[3:0],  mask_positions[4:0])
                    + pack_channel(s1_pix.green, mask_sizes[7:4],  mask_positions[9:5])
                    + pack_channel(s1_pix.blue,  mask_sizes[11:8], mask_positions[14:10]);

  always_comb begin
    result.byte_address = s1_addr;
    result.end_of_line  = s1_eol;
    result.end_of_frame = s1_eof;
    if (pixel_format == FMT_PACKED) begin
      result.pixel_bytes = {16'h0, packed_sum};
      result.byte_enable = BE_PACKED;
    end else begin
      if (mask_positions[14:10] == 5'd0) begin
        result.pixel_bytes = {8'h0, s1_pix.red, s1_pix.green, s1_pix.blue};
      end else begin
        result.pixel_bytes = {8'h0, s1_pix.blue, s1_pix.green, s1_pix.red};
      end
      result.byte_enable = BE_WIDE;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (out_en) begin
      dst_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      dst_data <= result;
    end
  end

endmodule
